// ===== rtl/ddds_pkg.sv =====
// shared types, codes and divide-by-ten helpers for the decimal digit display scanner
package ddds_pkg;

  // action codes
  localparam logic [1:0] ACT_FULL  = 2'd0;
  localparam logic [1:0] ACT_RIGHT = 2'd1;
  localparam logic [1:0] ACT_LEFT  = 2'd2;
  localparam logic [1:0] ACT_NONE  = 2'd3;

  // reciprocal of ten, exact for every 16-bit value
  localparam logic [31:0] DIV10_MUL   = 32'd52429;
  localparam int          DIV10_SHIFT = 19;
  localparam int          QUOT_W      = 13;

  // digit positions and last index of each mode
  localparam logic [1:0] POS_LEFT_BASE = 2'd2;
  localparam logic [1:0] IDX_LAST_FULL = 2'd3;
  localparam logic [1:0] IDX_LAST_PAIR = 2'd1;

  typedef struct packed {
    logic [15:0] value;
    logic [1:0]  action;
  } in_t;

  typedef struct packed {
    logic [1:0] digit_position;
    logic [4:0] segment_code;
    logic       last_digit;
  } out_t;

  // quotient of x by ten
  function automatic logic [QUOT_W-1:0] div10(input logic [15:0] x);
    logic [31:0] p;
    p = 32'(x) * DIV10_MUL;
    return p[DIV10_SHIFT +: QUOT_W];
  endfunction

  // remainder of x by ten, given its quotient
  function automatic logic [3:0] rem10(input logic [15:0] x, input logic [QUOT_W-1:0] q);
    logic [15:0] r;
    r = x - ((16'(q) << 3) + (16'(q) << 1));
    return r[3:0];
  endfunction

  // bcd digit to port code: bit 3 moves to bit 4
  function automatic logic [4:0] port_code(input logic [3:0] d);
    return {d[3], 1'b0, d[2:0]};
  endfunction

endpackage

// ===== rtl/decimal_digit_display_scanner_top.sv =====
// top level of the decimal digit display scanner: divide pipeline and digit serializer
//
// A transaction is taken when start is high and busy is low. The value passes four
// register stages, each peeling off one decimal digit with a reciprocal multiply, then
// a serializer emits one digit per cycle: four results in full mode, two in either pair
// mode, none for action 3. Results are strobed by result_valid_o for a single cycle and
// cannot be held off. A taken transaction passes the stage registers s1 to s4 and then the
// serializer register before its first result shows; a new transaction can be taken every
// cycle while the pipeline has room, and the sustained rate is set by the serializer, which
// shows every digit of one transaction before it takes the next. Stalled stages hold their
// contents, busy rises when the first stage cannot move on.
module decimal_digit_display_scanner_top (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  ddds_pkg::in_t    in_i,
  output logic             result_valid_o,
  output ddds_pkg::out_t   result_o
);
  import ddds_pkg::*;

  // stage valid bits
  logic s1_v_q, s2_v_q, s3_v_q, s4_v_q, ser_v_q;
  logic s1_v_d, s2_v_d, s3_v_d, s4_v_d, ser_v_d;

  // stage payloads
  logic [15:0]       s1_val_q;
  logic [1:0]        s1_act_q;
  logic [QUOT_W-1:0] s2_quo_q;
  logic [1:0]        s2_act_q;
  logic [3:0]        s2_d0_q;
  logic [9:0]        s3_quo_q;
  logic [1:0]        s3_act_q;
  logic [3:0]        s3_d0_q, s3_d1_q;
  logic [6:0]        s4_quo_q;
  logic [1:0]        s4_act_q;
  logic [3:0]        s4_d0_q, s4_d1_q, s4_d2_q;
  logic [3:0]        ser_dig_q [4];
  logic [1:0]        ser_act_q;
  logic [1:0]        ser_idx_q, ser_idx_d;

  logic rdy1, rdy2, rdy3, rdy4, ser_last, take;
  logic [QUOT_W-1:0] q1, q2, q3, q4;

  // ready chain from the serializer back to the first stage
  assign ser_last = (ser_act_q == ACT_FULL) ? (ser_idx_q == IDX_LAST_FULL)
                                            : (ser_idx_q == IDX_LAST_PAIR);
  assign rdy4 = !ser_v_q || ser_last;
  assign rdy3 = !s4_v_q || rdy4;
  assign rdy2 = !s3_v_q || rdy3;
  assign rdy1 = !s2_v_q || rdy2;
  assign busy = s1_v_q && !rdy1;
  assign take = start && !busy;

  // divide by ten at each stage boundary
  assign q1 = div10(s1_val_q);
  assign q2 = div10(16'(s2_quo_q));
  assign q3 = div10(16'(s3_quo_q));
  assign q4 = div10(16'(s4_quo_q));

  // valid bits and serializer index
  always_comb begin
    s1_v_d = s1_v_q;
    if (!s1_v_q || rdy1) begin
      s1_v_d = take && (in_i.action != ACT_NONE);
    end
    s2_v_d = rdy1 ? s1_v_q : s2_v_q;
    s3_v_d = rdy2 ? s2_v_q : s3_v_q;
    s4_v_d = rdy3 ? s3_v_q : s4_v_q;
    ser_v_d   = ser_v_q;
    ser_idx_d = ser_idx_q;
    if (rdy4) begin
      ser_v_d   = s4_v_q;
      ser_idx_d = '0;
    end else begin
      ser_idx_d = ser_idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q    <= 1'b0;
      s2_v_q    <= 1'b0;
      s3_v_q    <= 1'b0;
      s4_v_q    <= 1'b0;
      ser_v_q   <= 1'b0;
      ser_idx_q <= '0;
    end else begin
      s1_v_q    <= s1_v_d;
      s2_v_q    <= s2_v_d;
      s3_v_q    <= s3_v_d;
      s4_v_q    <= s4_v_d;
      ser_v_q   <= ser_v_d;
      ser_idx_q <= ser_idx_d;
    end
  end

  // payload registers, each stage moves when the next has room
  always_ff @(posedge clk_i) begin
    if (!s1_v_q || rdy1) begin
      s1_val_q <= in_i.value;
      s1_act_q <= in_i.action;
    end
    if (rdy1) begin
      s2_quo_q <= q1;
      s2_d0_q  <= rem10(s1_val_q, q1);
      s2_act_q <= s1_act_q;
    end
    if (rdy2) begin
      s3_quo_q <= q2[9:0];
      s3_d0_q  <= s2_d0_q;
      s3_d1_q  <= rem10(16'(s2_quo_q), q2);
      s3_act_q <= s2_act_q;
    end
    if (rdy3) begin
      s4_quo_q <= q3[6:0];
      s4_d0_q  <= s3_d0_q;
      s4_d1_q  <= s3_d1_q;
      s4_d2_q  <= rem10(16'(s3_quo_q), q3);
      s4_act_q <= s3_act_q;
    end
    if (rdy4) begin
      ser_dig_q[0] <= s4_d0_q;
      ser_dig_q[1] <= s4_d1_q;
      ser_dig_q[2] <= s4_d2_q;
      ser_dig_q[3] <= rem10(16'(s4_quo_q), q4);
      ser_act_q    <= s4_act_q;
    end
  end

  // result fields from the serializer registers
  always_comb begin
    result_valid_o          = ser_v_q;
    result_o.digit_position = (ser_act_q == ACT_LEFT) ? (ser_idx_q + POS_LEFT_BASE) : ser_idx_q;
    result_o.segment_code   = port_code(ser_dig_q[ser_idx_q]);
    result_o.last_digit     = ser_last;
  end

endmodule

// ===== rtl/ddds_checker.sv =====
// port-level checks for the decimal digit display scanner and their bind
module ddds_port_checks (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           busy,
  input logic           result_valid_o,
  input ddds_pkg::out_t result_o
);

  // digits of one transaction come out on consecutive cycles
  a_burst_contiguous: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !result_o.last_digit |=> result_valid_o)
    else $error("digit burst broken");

  // positions climb by one within a transaction
  a_position_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !result_o.last_digit |=>
      result_o.digit_position == $past(result_o.digit_position) + 2'd1)
    else $error("digit position did not advance");

  // a burst ends on position one or three
  a_last_position: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && result_o.last_digit |->
      result_o.digit_position == 2'd1 || result_o.digit_position == 2'd3)
    else $error("last digit on wrong position");

  // port code holds a decimal digit only
  a_code_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !result_o.segment_code[3] &&
      (!result_o.segment_code[4] || result_o.segment_code[2:1] == 2'b00))
    else $error("segment code is not a decimal digit");

  // busy only while a burst is still being shown
  a_busy_in_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> result_valid_o && !result_o.last_digit)
    else $error("busy without a burst in progress");

endmodule

bind decimal_digit_display_scanner_top ddds_port_checks u_ddds_port_checks (.*);
